>>> rtl/core/mosaic_pixel_blend_weight_unit_defines.svh
// ----------------------------------------------------------------------------
// Mosaic pixel blend weight unit: assertion macros
// Shared property forms for the port-level checker. Both sample on i_clk and
// are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOSAIC_PIXEL_BLEND_WEIGHT_UNIT_DEFINES_SVH
`define MOSAIC_PIXEL_BLEND_WEIGHT_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define MPBW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpbw port check failed");

// condition holds at every sampled edge
`define MPBW_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mpbw port check failed");

`endif

>>> rtl/core/mpbw_pkg.sv
// ----------------------------------------------------------------------------
// mpbw_pkg
// Types and constants shared by the mosaic pixel blend weight unit.
// ----------------------------------------------------------------------------
package mpbw_pkg;

    // field widths
    localparam int DIM_W     = 14;
    localparam int COORD_W   = 18;
    localparam int CAM_W     = 16;
    localparam int WGT_W     = 16;
    localparam int CFG_IDX_W = 2;

    // fixed-point formats: coordinates Q14.4, factors Q0.16
    localparam int COORD_FRAC = 4;
    localparam int WEIGHT_FRAC = 16;

    // factor constants, 17 bits so that 1.0 fits
    localparam logic [16:0] FACT_ONE  = 17'h10000;
    localparam logic [16:0] FACT_HALF = 17'h08000;
    localparam logic [16:0] FACT_EPS  = 17'd66;     // round(1.0 / 1000)

    localparam logic [DIM_W-1:0] DIM_RESET = 14'd1024;
    localparam logic [DIM_W-1:0] DIM_MIN   = 14'd2;

    // accept edge to strobe sample edge
    localparam int PIPE_LATENCY = 40;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_reg;

    // operands handed from the front end to the divider chains
    typedef struct packed {
        logic [13:0] edge_r0;
        logic [15:0] edge_lo;
        logic        edge_nonpos;
        logic        edge_big;
        logic [13:0] cx_r0;
        logic [15:0] cx_lo;
        logic        cx_cap;
        logic [13:0] cy_r0;
        logic [15:0] cy_lo;
        logic        cy_cap;
        logic [31:0] prox_r0;
        logic [16:0] prox_lo;
        logic [31:0] prox_den;
    } t_prep;

endpackage

>>> rtl/core/mpbw_delay.sv
// ----------------------------------------------------------------------------
// mpbw_delay
// Fixed-length register delay line for pipeline payload alignment.
// ----------------------------------------------------------------------------
module mpbw_delay #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 19
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // shift one tap per cycle
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

>>> rtl/core/mpbw_prep.sv
// ----------------------------------------------------------------------------
// mpbw_prep
// Two-stage front end: border distances, center offsets and the proximity
// denominator, then divider operands and range flags.
// ----------------------------------------------------------------------------
module mpbw_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [17:0]    i_coord_x,
    input  logic signed [17:0]    i_coord_y,
    input  logic [15:0]           i_cam_dist,
    input  logic [13:0]           i_width,
    input  logic [13:0]           i_height,
    output logic                  o_valid,
    output mpbw_pkg::t_prep       o_prep
);

    // stage 1 registers
    logic               r_v1;
    logic signed [19:0] r_x;
    logic signed [19:0] r_y;
    logic signed [19:0] r_right;
    logic signed [19:0] r_bottom;
    logic signed [20:0] r_nx;
    logic signed [20:0] r_ny;
    logic [31:0]        r_dsq;

    // stage 2 registers
    logic               r_v2;
    mpbw_pkg::t_prep    r_prep;

    // stage 1 combinational
    logic signed [19:0] x_ext;
    logic signed [19:0] y_ext;
    logic [13:0]        wm1;
    logic [13:0]        hm1;

    // stage 2 combinational
    logic signed [19:0] m_a;
    logic signed [19:0] m_b;
    logic signed [19:0] m_min;
    logic               nonpos;
    logic               big;
    logic [20:0]        ax_full;
    logic [20:0]        ay_full;
    logic [19:0]        ax;
    logic [19:0]        ay;
    logic               capx;
    logic               capy;
    logic [31:0]        den;
    mpbw_pkg::t_prep    n_prep;

    assign x_ext = {{2{i_coord_x[17]}}, i_coord_x};
    assign y_ext = {{2{i_coord_y[17]}}, i_coord_y};
    assign wm1   = i_width - 14'd1;
    assign hm1   = i_height - 14'd1;

    // stage 1: far border distances, doubled center offsets, d squared
    always_ff @(posedge i_clk) begin
        r_x      <= x_ext;
        r_y      <= y_ext;
        r_right  <= $signed({2'b00, wm1, 4'b0000}) - x_ext;
        r_bottom <= $signed({2'b00, hm1, 4'b0000}) - y_ext;
        r_nx     <= $signed({{2{i_coord_x[17]}}, i_coord_x, 1'b0})
                    - $signed({3'b000, i_width, 4'b0000});
        r_ny     <= $signed({{2{i_coord_y[17]}}, i_coord_y, 1'b0})
                    - $signed({3'b000, i_height, 4'b0000});
        r_dsq    <= i_cam_dist * i_cam_dist;
    end

    // stage 2: nearest border, magnitudes, divider operands
    always_comb begin
        m_a     = (r_right < r_x) ? r_right : r_x;
        m_b     = (r_bottom < r_y) ? r_bottom : r_y;
        m_min   = (m_b < m_a) ? m_b : m_a;
        nonpos  = (m_min <= 20'sd0);
        big     = !nonpos && ($unsigned(m_min) >= {3'b000, i_width, 3'b000});

        ax_full = r_nx[20] ? 21'(-r_nx) : 21'(r_nx);
        ay_full = r_ny[20] ? 21'(-r_ny) : 21'(r_ny);
        ax      = ax_full[19:0];
        ay      = ay_full[19:0];
        capx    = (ax >= {2'b00, i_width, 4'b0000});
        capy    = (ay >= {2'b00, i_height, 4'b0000});

        den     = r_dsq + 32'h0001_0000;

        // edge: quotient of m * 2^13 by W
        n_prep.edge_r0     = (nonpos || big) ? 14'd0 : m_min[16:3];
        n_prep.edge_lo     = {m_min[2:0], 13'd0};
        n_prep.edge_nonpos = nonpos;
        n_prep.edge_big    = big;
        // center axes: quotient of |offset| * 2^12 by the axis size
        n_prep.cx_r0       = capx ? 14'd0 : ax[17:4];
        n_prep.cx_lo       = {ax[3:0], 12'd0};
        n_prep.cx_cap      = capx;
        n_prep.cy_r0       = capy ? 14'd0 : ay[17:4];
        n_prep.cy_lo       = {ay[3:0], 12'd0};
        n_prep.cy_cap      = capy;
        // proximity: (2^32 + den/2) / den, first 16 bits go in as remainder
        n_prep.prox_r0     = {16'd0, 2'b10, den[31:18]};
        n_prep.prox_lo     = den[17:1];
        n_prep.prox_den    = den;
    end

    always_ff @(posedge i_clk) begin
        r_prep <= n_prep;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_prep  = r_prep;

endmodule

>>> rtl/core/mpbw_div.sv
// ----------------------------------------------------------------------------
// mpbw_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must already be below the divisor; low dividend bits shift in.
// ----------------------------------------------------------------------------
module mpbw_div #(
    parameter int DW = 14,
    parameter int QB = 16,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [DW-1:0] i_r0,
    input  logic [QB-1:0] i_lo,
    input  logic [DW-1:0] i_div,
    input  logic [TW-1:0] i_tag,
    output logic [QB-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [QB-1];
    logic [QB-1:0] r_lo  [QB-1];
    logic [DW-1:0] r_div [QB-1];
    logic [QB-1:0] r_quo [QB];
    logic [TW-1:0] r_tag [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QB-1:0] lo_in;
        logic [DW-1:0] div_in;
        logic [QB-1:0] quo_in;
        logic [TW-1:0] tag_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in = i_r0;
            assign lo_in  = i_lo;
            assign div_in = i_div;
            assign quo_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign lo_in  = r_lo[s-1];
            assign div_in = r_div[s-1];
            assign quo_in = r_quo[s-1];
            assign tag_in = r_tag[s-1];
        end

        // shift in next dividend bit, subtract if it fits
        assign trial = {rem_in, lo_in[QB-1]};
        assign diff  = trial - {1'b0, div_in};
        assign take  = (trial >= {1'b0, div_in});

        always_ff @(posedge i_clk) begin
            r_quo[s] <= {quo_in[QB-2:0], take};
        end

        if (s < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= take ? diff[DW-1:0] : trial[DW-1:0];
                r_lo[s]  <= {lo_in[QB-2:0], 1'b0};
                r_div[s] <= div_in;
            end
        end

        // tag may carry a valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= tag_in;
            end
        end
    end

    assign o_quo = r_quo[QB-1];
    assign o_tag = r_tag[QB-1];

endmodule

>>> rtl/core/mpbw_center.sv
// ----------------------------------------------------------------------------
// mpbw_center
// Center factor: squares of the normalized axis offsets, their sum, a
// 16-stage pipelined integer square root, then 1 - r/2.
// ----------------------------------------------------------------------------
module mpbw_center (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_cx_q,
    input  logic        i_cx_cap,
    input  logic [15:0] i_cy_q,
    input  logic        i_cy_cap,
    input  logic        i_valid,     // arrives the cycle after the axis quotients
    output logic [16:0] o_center,
    output logic        o_valid
);

    localparam int SQ_STAGES = 16;

    logic [16:0] cx;
    logic [16:0] cy;
    logic [32:0] r_sqx;
    logic [32:0] r_sqy;
    logic [33:0] sum;

    logic        r_vb;
    logic        r_big;
    logic [31:0] r_rad;

    logic [31:0] r_sv   [SQ_STAGES-1];
    logic [31:0] r_res  [SQ_STAGES];
    logic        r_sbig [SQ_STAGES];
    logic        r_sval [SQ_STAGES];

    logic        r_vc;
    logic [16:0] r_center;

    // stage A: square the capped axis terms
    assign cx = i_cx_cap ? mpbw_pkg::FACT_ONE : {1'b0, i_cx_q};
    assign cy = i_cy_cap ? mpbw_pkg::FACT_ONE : {1'b0, i_cy_q};

    always_ff @(posedge i_clk) begin
        r_sqx <= 33'(cx * cx);
        r_sqy <= 33'(cy * cy);
    end

    // stage B: radius squared, saturate at one
    assign sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        r_big <= (sum[33:32] != 2'b00);
        r_rad <= sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= i_valid;
        end
    end

    // digit-by-digit root, one result bit per stage
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * s);
        logic [31:0] v_in;
        logic [31:0] res_in;
        logic        big_in;
        logic        val_in;
        logic [32:0] trial;
        logic        take;

        if (s == 0) begin : g_first
            assign v_in   = r_rad;
            assign res_in = '0;
            assign big_in = r_big;
            assign val_in = r_vb;
        end else begin : g_next
            assign v_in   = r_sv[s-1];
            assign res_in = r_res[s-1];
            assign big_in = r_sbig[s-1];
            assign val_in = r_sval[s-1];
        end

        assign trial = {1'b0, res_in} + {1'b0, BIT};
        assign take  = ({1'b0, v_in} >= trial);

        always_ff @(posedge i_clk) begin
            r_res[s]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
            r_sbig[s] <= big_in;
        end

        if (s < SQ_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_sv[s] <= take ? (v_in - trial[31:0]) : v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sval[s] <= 1'b0;
            end else begin
                r_sval[s] <= val_in;
            end
        end
    end

    // stage C: factor = 1 - root/2, or one half when saturated
    always_ff @(posedge i_clk) begin
        r_center <= r_sbig[SQ_STAGES-1] ? mpbw_pkg::FACT_HALF
                  : mpbw_pkg::FACT_ONE - {2'b00, r_res[SQ_STAGES-1][15:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_sval[SQ_STAGES-1];
        end
    end

    assign o_center = r_center;
    assign o_valid  = r_vc;

endmodule

>>> rtl/core/mosaic_pixel_blend_weight_unit.sv
// ----------------------------------------------------------------------------
// mosaic_pixel_blend_weight_unit
// Per-pixel mosaic blend weight: edge, center and proximity factors, product.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel word is taken on every clock (busy stays low) and
// its weight appears on o_blend_weight with o_done, one cycle wide, in input
// order. The depth comes from the two-stage front end, the bit-serial divider
// chains (16 stages for the edge and axis quotients, 17 for the proximity
// reciprocal), the square and sum registers, the 16-stage square root and
// final register of the center factor, and the three-register product and
// saturate stage. The receiver has no way to hold results off, so o_done
// words must be captured when shown. Image width and height are to be written
// only while no pixel is in flight; the block itself does not enforce this.
// Values below 2 are stored as 2.
module mosaic_pixel_blend_weight_unit #(
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [17:0]   i_coord_x,
    input  logic signed [17:0]   i_coord_y,
    input  logic [15:0]          i_cam_dist,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [13:0]          i_cfg_data,
    output logic                 o_done,
    output logic [15:0]          o_blend_weight
);

    localparam int ALIGN_DEPTH = 19;

    logic [13:0]     r_width;
    logic [13:0]     r_height;
    logic [13:0]     cfg_dim;

    logic            prep_valid;
    mpbw_pkg::t_prep prep;

    logic [15:0]     edge_q;
    logic [1:0]      edge_tag;
    logic [15:0]     cx_q;
    logic            cx_cap;
    logic [15:0]     cy_q;
    logic            cy_cap;
    logic [16:0]     prox_q;
    logic            prox_valid;

    logic [16:0]     edge_fact;
    logic [16:0]     edge_al;
    logic [16:0]     prox_al;
    logic [16:0]     center;
    logic            center_valid;

    logic [33:0]     prod1;
    logic [33:0]     prod2;
    logic [16:0]     r_t;
    logic [16:0]     r_w;
    logic            r_vt;
    logic            r_vw;
    logic            r_done;
    logic [15:0]     r_weight;

    // configuration registers, degenerate sizes stored as two
    assign cfg_dim = (i_cfg_data < mpbw_pkg::DIM_MIN) ? mpbw_pkg::DIM_MIN : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mpbw_pkg::DIM_RESET;
            r_height <= mpbw_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (mpbw_pkg::t_cfg_reg'(i_cfg_idx))
                mpbw_pkg::CFG_WIDTH:  r_width  <= cfg_dim;
                mpbw_pkg::CFG_HEIGHT: r_height <= cfg_dim;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front end
    mpbw_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_cam_dist (i_cam_dist),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (prep_valid),
        .o_prep     (prep)
    );

    // edge quotient
    mpbw_div #(.DW(14), .QB(16), .TW(2)) u_div_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_r0    (prep.edge_r0),
        .i_lo    (prep.edge_lo),
        .i_div   (r_width),
        .i_tag   ({prep.edge_nonpos, prep.edge_big}),
        .o_quo   (edge_q),
        .o_tag   (edge_tag)
    );

    // center axis quotients
    mpbw_div #(.DW(14), .QB(16), .TW(1)) u_div_cx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_r0    (prep.cx_r0),
        .i_lo    (prep.cx_lo),
        .i_div   (r_width),
        .i_tag   (prep.cx_cap),
        .o_quo   (cx_q),
        .o_tag   (cx_cap)
    );

    mpbw_div #(.DW(14), .QB(16), .TW(1)) u_div_cy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_r0    (prep.cy_r0),
        .i_lo    (prep.cy_lo),
        .i_div   (r_height),
        .i_tag   (prep.cy_cap),
        .o_quo   (cy_q),
        .o_tag   (cy_cap)
    );

    // proximity reciprocal, carries the word valid
    mpbw_div #(.DW(32), .QB(17), .TW(1)) u_div_prox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_r0    (prep.prox_r0),
        .i_lo    (prep.prox_lo),
        .i_div   (prep.prox_den),
        .i_tag   (prep_valid),
        .o_quo   (prox_q),
        .o_tag   (prox_valid)
    );

    // edge factor clamp to [eps, 1]
    always_comb begin
        if (edge_tag[1]) begin
            edge_fact = mpbw_pkg::FACT_EPS;
        end else if (edge_tag[0]) begin
            edge_fact = mpbw_pkg::FACT_ONE;
        end else if ({1'b0, edge_q} < mpbw_pkg::FACT_EPS) begin
            edge_fact = mpbw_pkg::FACT_EPS;
        end else begin
            edge_fact = {1'b0, edge_q};
        end
    end

    mpbw_center u_center (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cx_q   (cx_q),
        .i_cx_cap (cx_cap),
        .i_cy_q   (cy_q),
        .i_cy_cap (cy_cap),
        .i_valid  (prox_valid),
        .o_center (center),
        .o_valid  (center_valid)
    );

    // align edge with the center factor and proximity with the first product
    mpbw_delay #(.WIDTH(17), .DEPTH(ALIGN_DEPTH)) u_dly_edge (
        .i_clk  (i_clk),
        .i_data (edge_fact),
        .o_data (edge_al)
    );

    mpbw_delay #(.WIDTH(17), .DEPTH(ALIGN_DEPTH)) u_dly_prox (
        .i_clk  (i_clk),
        .i_data (prox_q),
        .o_data (prox_al)
    );

    // product: edge * center, then * proximity, then saturate
    assign prod1 = edge_al * center;
    assign prod2 = r_t * prox_al;

    always_ff @(posedge i_clk) begin
        r_t      <= prod1[32:16];
        r_w      <= prod2[32:16];
        r_weight <= r_w[16] ? 16'hFFFF : r_w[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vt   <= 1'b0;
            r_vw   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vt   <= center_valid;
            r_vw   <= r_vt;
            r_done <= r_vw;
        end
    end

    assign o_done         = r_done;
    assign o_blend_weight = r_weight;

endmodule

>>> rtl/core/mpbw_checker.sv
// ----------------------------------------------------------------------------
// mpbw_checker
// Port-level checks for the blend weight unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mosaic_pixel_blend_weight_unit_defines.svh"

module mpbw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic signed [17:0]   i_coord_x,
    input logic signed [17:0]   i_coord_y,
    input logic [15:0]          i_cam_dist,
    input logic                 i_cfg_we,
    input logic [1:0]           i_cfg_idx,
    input logic [13:0]          i_cfg_data,
    input logic                 o_done,
    input logic [15:0]          o_blend_weight
);

    // the pipeline never pushes back
    `MPBW_ASSERT_ALWAYS(a_never_busy, !busy)

    // every result word traces to an accepted pixel at fixed latency
    `MPBW_ASSERT_IMP(a_done_has_source, o_done, $past(start && !busy, mpbw_pkg::PIPE_LATENCY))

    // a column left of the image pins the edge factor at eps
    `MPBW_ASSERT_IMP(a_outside_small, o_done && $past(i_coord_x[17], mpbw_pkg::PIPE_LATENCY), o_blend_weight <= 16'd66)

    // a far camera drives proximity down to a few LSBs
    `MPBW_ASSERT_IMP(a_far_small, o_done && $past(i_cam_dist[15], mpbw_pkg::PIPE_LATENCY), o_blend_weight <= 16'd4)

endmodule

bind mosaic_pixel_blend_weight_unit mpbw_checker u_mpbw_checker (.*);
